### hw/rtl/executor_slot_reservation_table_top_defines.svh
// Assertion macros for the executor slot reservation table.
// Used by executor_slot_reservation_table_top; needs clk and rst_n in scope.
`ifndef EXECUTOR_SLOT_RESERVATION_TABLE_TOP_DEFINES_SVH
`define EXECUTOR_SLOT_RESERVATION_TABLE_TOP_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define ESRT_ASSERT_IMPLIES(lbl, a, b, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define ESRT_ASSERT_NEXT(lbl, a, b, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) else $error(msg);

`endif

### hw/rtl/esrt_pkg.sv
// Package for the executor slot reservation table.
// Holds sizes, item and command types, codes and saturating arithmetic; no dependencies.
package esrt_pkg;

    localparam int MAX_EXECUTORS = 8;
    localparam int LIST_DEPTH    = 32;
    localparam int CYCLE_BITS    = 32;

    localparam int EX_IDX_W = (MAX_EXECUTORS > 1) ? $clog2(MAX_EXECUTORS) : 1;
    localparam int EX_CNT_W = $clog2(MAX_EXECUTORS + 1);
    localparam int CNT_W    = $clog2(LIST_DEPTH + 1);

    typedef logic [CYCLE_BITS-1:0] cyc_t;

    localparam cyc_t CYC_MAX = '1;

    // Operation codes; the last one is unused and only returns a zero result.
    localparam logic [1:0] OP_FIND   = 2'd0;
    localparam logic [1:0] OP_SCHED  = 2'd1;
    localparam logic [1:0] OP_STALL  = 2'd2;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    // Status codes.
    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_BAD_MASK = 2'd1;
    localparam logic [1:0] STATUS_FULL     = 2'd2;

    typedef struct packed {
        logic [1:0]  operation;
        logic        need_all;
        logic [31:0] cycle_begin;
        logic [31:0] cycle_cost;
        logic [63:0] executor_mask;
    } esrt_in_t;

    typedef struct packed {
        logic [31:0] slot_cycle;
        logic [63:0] slot_mask;
        logic [1:0]  status;
    } esrt_out_t;

    // Command broadcast to the cells of one executor row.
    typedef struct packed {
        logic ins;
        logic stall;
        cyc_t a;        // Interval start, or first stalled cycle.
        cyc_t b;        // Interval length, or stall delay.
        cyc_t new_end;  // Saturated end of the interval being inserted.
    } esrt_cmd_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CHECK,
        S_SCAN,
        S_APPLY
    } esrt_state_t;

    // Saturating add at the cycle width.
    function automatic cyc_t sat_add(input cyc_t a, input cyc_t b);
        logic [CYCLE_BITS:0] s;
        begin
            s = {1'b0, a} + {1'b0, b};
            return s[CYCLE_BITS] ? CYC_MAX : s[CYCLE_BITS-1:0];
        end
    endfunction

    // Mask with one bit for each executor in use.
    function automatic logic [63:0] all_bits(input logic [EX_CNT_W-1:0] n);
        logic [63:0] m;
        begin
            m = '0;
            for (int i = 0; i < MAX_EXECUTORS; i++)
            begin
                if (EX_CNT_W'(i) < n)
                    m[i] = 1'b1;
            end
            return m;
        end
    endfunction

endpackage

### hw/rtl/esrt_cell.sv
// One reserved interval of an executor list.
// Depends on esrt_pkg; shifts in from its left neighbor on an insert.
module esrt_cell (
    input  logic                clk,
    input  esrt_pkg::esrt_cmd_t cmd,
    input  logic                valid,
    input  logic                at_tail,
    input  logic                hit_in,
    input  esrt_pkg::cyc_t      left_start,
    input  esrt_pkg::cyc_t      left_len,
    output esrt_pkg::cyc_t      start,
    output esrt_pkg::cyc_t      len,
    output logic                hit_out
);

    esrt_pkg::cyc_t start_reg, start_next;
    esrt_pkg::cyc_t len_reg, len_next;
    logic           gt;

    // This entry ends after the new interval: the insert lands here or earlier.
    assign gt      = valid && (esrt_pkg::sat_add(start_reg, len_reg) > cmd.new_end);
    assign hit_out = hit_in | gt;
    assign start   = start_reg;
    assign len     = len_reg;

    // Next entry value: shift right, take the new interval, or stall.
    always_comb
    begin
        start_next = start_reg;
        len_next   = len_reg;
        if (cmd.ins)
        begin
            if (hit_in && (valid || at_tail))
            begin
                start_next = left_start;
                len_next   = left_len;
            end
            else if (!hit_in && (gt || at_tail))
            begin
                start_next = cmd.a;
                len_next   = cmd.b;
            end
        end
        else if (cmd.stall && valid && (start_reg >= cmd.a))
        begin
            start_next = esrt_pkg::sat_add(start_reg, cmd.b);
        end
    end

    always_ff @(posedge clk)
    begin
        start_reg <= start_next;
        len_reg   <= len_next;
    end

endmodule

### hw/rtl/esrt_row.sv
// Interval list of one executor: a chain of cells plus fill count and last entry.
// Depends on esrt_pkg and esrt_cell.
module esrt_row (
    input  logic                clk,
    input  logic                rst_n,
    input  esrt_pkg::esrt_cmd_t cmd,
    output esrt_pkg::cyc_t      last_end,
    output logic                full
);

    logic [esrt_pkg::CNT_W-1:0] count_reg, count_next;
    esrt_pkg::cyc_t             last_start_reg, last_start_next;
    esrt_pkg::cyc_t             last_len_reg, last_len_next;

    esrt_pkg::cyc_t cell_start [esrt_pkg::LIST_DEPTH];
    esrt_pkg::cyc_t cell_len   [esrt_pkg::LIST_DEPTH];
    logic [esrt_pkg::LIST_DEPTH:0] hit;

    assign hit[0] = 1'b0;

    // The chain of cells; cell zero never shifts, so its left input is the command.
    for (genvar i = 0; i < esrt_pkg::LIST_DEPTH; i++)
    begin : g_cell
        esrt_pkg::cyc_t ls, ll;
        if (i == 0)
        begin : g_first
            assign ls = cmd.a;
            assign ll = cmd.b;
        end
        else
        begin : g_rest
            assign ls = cell_start[i-1];
            assign ll = cell_len[i-1];
        end
        esrt_cell u_cell (
            .clk        (clk),
            .cmd        (cmd),
            .valid      (esrt_pkg::CNT_W'(i) < count_reg),
            .at_tail    (esrt_pkg::CNT_W'(i) == count_reg),
            .hit_in     (hit[i]),
            .left_start (ls),
            .left_len   (ll),
            .start      (cell_start[i]),
            .len        (cell_len[i]),
            .hit_out    (hit[i+1])
        );
    end

    assign full     = (count_reg == esrt_pkg::CNT_W'(esrt_pkg::LIST_DEPTH));
    assign last_end = (count_reg == '0) ? '0 : esrt_pkg::sat_add(last_start_reg, last_len_reg);

    // Fill count and a copy of the last entry, kept for the slot search.
    always_comb
    begin
        count_next      = count_reg;
        last_start_next = last_start_reg;
        last_len_next   = last_len_reg;
        if (cmd.ins)
        begin
            count_next = count_reg + 1'b1;
            if (!hit[esrt_pkg::LIST_DEPTH])
            begin
                last_start_next = cmd.a;
                last_len_next   = cmd.b;
            end
        end
        else if (cmd.stall && (count_reg != '0) && (last_start_reg >= cmd.a))
        begin
            last_start_next = esrt_pkg::sat_add(last_start_reg, cmd.b);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else
            count_reg <= count_next;
    end

    always_ff @(posedge clk)
    begin
        last_start_reg <= last_start_next;
        last_len_reg   <= last_len_next;
    end

endmodule

### hw/rtl/executor_slot_reservation_table_top.sv
// Executor slot reservation table: one group of executors with interval lists.
// Depends on esrt_pkg, esrt_row and the assertion macro header.
//
// Usage:
//   An item (find slot, schedule interval or insert stall) is taken on a
//   clock edge with start high and busy low. busy stays high until the
//   result is ready. The result is shown on result for exactly one cycle
//   with done high; the receiver cannot stall it and must take it then.
//   A schedule or stall item passes through the check and apply states; a
//   bad-mask or full schedule or an unused operation ends after the check,
//   and a find slot goes on to the slot search, which walks one executor a
//   cycle over the last-entry ends. The next item can be taken at the edge
//   that ends the done cycle. Insert acts on all cells of the rows in the
//   item's mask at once, and stall on all cells of the rows in use.
//   The user must write executor_count with cfg_wr_en/cfg_wr_data only
//   while busy is low; the block itself does not enforce it.
//   Reset clears every fill count and sets executor_count to 1; the entry
//   storage itself is not cleared and needs no clearing pass.
`include "executor_slot_reservation_table_top_defines.svh"

module executor_slot_reservation_table_top (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  esrt_pkg::esrt_in_t item,
    output logic               done,
    output esrt_pkg::esrt_out_t result,
    input  logic               cfg_wr_en,
    input  logic [6:0]         cfg_wr_data
);

    esrt_pkg::esrt_state_t state_reg, state_next;
    esrt_pkg::esrt_in_t    item_reg, item_next;
    esrt_pkg::cyc_t        new_end_reg, new_end_next;
    esrt_pkg::cyc_t        best_end_reg, best_end_next;
    logic [esrt_pkg::EX_IDX_W-1:0] best_reg, best_next;
    logic [esrt_pkg::EX_CNT_W-1:0] scan_reg, scan_next;
    esrt_pkg::esrt_out_t   res_reg, res_next;
    logic                  done_reg, done_next;
    logic [6:0]            exec_cnt_reg;

    logic [esrt_pkg::EX_CNT_W-1:0]      n_use;
    logic [63:0]                        use_mask;
    logic [6:0]                         pc;
    logic                               mask_bad;
    logic                               list_full;
    logic                               ins_go, stall_go;
    logic                               res_err;
    esrt_pkg::cyc_t                     scan_end;
    esrt_pkg::cyc_t                     row_end  [esrt_pkg::MAX_EXECUTORS];
    logic [esrt_pkg::MAX_EXECUTORS-1:0] row_full;
    esrt_pkg::esrt_cmd_t                row_cmd  [esrt_pkg::MAX_EXECUTORS];

    // Executors in use, with out-of-range counts clamped.
    always_comb
    begin
        if (exec_cnt_reg == '0)
            n_use = esrt_pkg::EX_CNT_W'(1);
        else if (exec_cnt_reg > 7'(esrt_pkg::MAX_EXECUTORS))
            n_use = esrt_pkg::EX_CNT_W'(esrt_pkg::MAX_EXECUTORS);
        else
            n_use = esrt_pkg::EX_CNT_W'(exec_cnt_reg);
    end

    assign use_mask  = esrt_pkg::all_bits(n_use);
    assign pc        = 7'($countones(item_reg.executor_mask));
    assign mask_bad  = (|(item_reg.executor_mask & ~use_mask))
                       || ((pc != 7'd1) && (pc != 7'(n_use)));
    assign list_full = |(item_reg.executor_mask[esrt_pkg::MAX_EXECUTORS-1:0] & row_full);
    assign scan_end  = row_end[scan_reg[esrt_pkg::EX_IDX_W-1:0]];

    // Executor rows with their own command enables.
    for (genvar e = 0; e < esrt_pkg::MAX_EXECUTORS; e++)
    begin : g_row
        always_comb
        begin
            row_cmd[e].ins     = ins_go && item_reg.executor_mask[e];
            row_cmd[e].stall   = stall_go && (esrt_pkg::EX_CNT_W'(e) < n_use);
            row_cmd[e].a       = esrt_pkg::CYCLE_BITS'(item_reg.cycle_begin);
            row_cmd[e].b       = esrt_pkg::CYCLE_BITS'(item_reg.cycle_cost);
            row_cmd[e].new_end = new_end_reg;
        end
        esrt_row u_row (
            .clk      (clk),
            .rst_n    (rst_n),
            .cmd      (row_cmd[e]),
            .last_end (row_end[e]),
            .full     (row_full[e])
        );
    end

    // Sequencer: check, then search or apply where needed, then present the result.
    always_comb
    begin
        state_next    = state_reg;
        item_next     = item_reg;
        new_end_next  = new_end_reg;
        best_end_next = best_end_reg;
        best_next     = best_reg;
        scan_next     = scan_reg;
        res_next      = res_reg;
        done_next     = 1'b0;
        ins_go        = 1'b0;
        stall_go      = 1'b0;
        case (state_reg)
            esrt_pkg::S_IDLE:
            begin
                if (start)
                begin
                    item_next  = item;
                    state_next = esrt_pkg::S_CHECK;
                end
            end
            esrt_pkg::S_CHECK:
            begin
                res_next     = '0;
                new_end_next = esrt_pkg::sat_add(
                    esrt_pkg::CYCLE_BITS'(item_reg.cycle_begin),
                    esrt_pkg::CYCLE_BITS'(item_reg.cycle_cost));
                if (item_reg.operation == esrt_pkg::OP_FIND)
                begin
                    best_end_next = row_end[0];
                    best_next     = '0;
                    scan_next     = esrt_pkg::EX_CNT_W'(1);
                    state_next    = esrt_pkg::S_SCAN;
                end
                else if (item_reg.operation == esrt_pkg::OP_SCHED)
                begin
                    if (mask_bad)
                    begin
                        res_next.status = esrt_pkg::STATUS_BAD_MASK;
                        done_next       = 1'b1;
                        state_next      = esrt_pkg::S_IDLE;
                    end
                    else if (list_full)
                    begin
                        res_next.status = esrt_pkg::STATUS_FULL;
                        done_next       = 1'b1;
                        state_next      = esrt_pkg::S_IDLE;
                    end
                    else
                    begin
                        state_next = esrt_pkg::S_APPLY;
                    end
                end
                else if (item_reg.operation == esrt_pkg::OP_STALL)
                begin
                    state_next = esrt_pkg::S_APPLY;
                end
                else
                begin
                    done_next  = 1'b1;
                    state_next = esrt_pkg::S_IDLE;
                end
            end
            esrt_pkg::S_SCAN:
            begin
                if (scan_reg < n_use)
                begin
                    if (item_reg.need_all ? (scan_end > best_end_reg)
                                          : (scan_end < best_end_reg))
                    begin
                        best_end_next = scan_end;
                        best_next     = scan_reg[esrt_pkg::EX_IDX_W-1:0];
                    end
                    scan_next = scan_reg + 1'b1;
                end
                else
                begin
                    res_next.slot_cycle = 32'(best_end_reg);
                    res_next.slot_mask  = item_reg.need_all ? use_mask
                                                            : (64'd1 << best_reg);
                    res_next.status     = esrt_pkg::STATUS_OK;
                    done_next           = 1'b1;
                    state_next          = esrt_pkg::S_IDLE;
                end
            end
            esrt_pkg::S_APPLY:
            begin
                ins_go     = (item_reg.operation == esrt_pkg::OP_SCHED);
                stall_go   = (item_reg.operation == esrt_pkg::OP_STALL);
                done_next  = 1'b1;
                state_next = esrt_pkg::S_IDLE;
            end
            default:
            begin
                state_next = esrt_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= esrt_pkg::S_IDLE;
            done_reg     <= 1'b0;
            exec_cnt_reg <= 7'd1;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            if (cfg_wr_en)
                exec_cnt_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg     <= item_next;
        new_end_reg  <= new_end_next;
        best_end_reg <= best_end_next;
        best_reg     <= best_next;
        scan_reg     <= scan_next;
        res_reg      <= res_next;
    end

    assign busy    = (state_reg != esrt_pkg::S_IDLE);
    assign done    = done_reg;
    assign result  = res_reg;
    assign res_err = done && (result.status != esrt_pkg::STATUS_OK);

    // A result follows work, an accepted item starts work, errors carry no mask.
    `ESRT_ASSERT_IMPLIES(a_done_after_busy, done, $past(busy), "result without work")
    `ESRT_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted item did not start")
    `ESRT_ASSERT_IMPLIES(a_err_no_mask, res_err, result.slot_mask == 64'd0, "error with mask")

endmodule

### verif/tb_executor_slot_reservation_table_top.sv
// Self-checking testbench for executor_slot_reservation_table_top.
// Depends on esrt_pkg and the block's RTL; holds its own table predictor.
`timescale 1ns / 100ps

module tb_executor_slot_reservation_table_top;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam logic [31:0] CMAX = 32'hFFFF_FFFF;

    logic                clk;
    logic                rst_n;
    logic                start;
    logic                busy;
    esrt_pkg::esrt_in_t  item;
    logic                done;
    esrt_pkg::esrt_out_t result;
    logic                cfg_wr_en;
    logic [6:0]          cfg_wr_data;

    // Predictor state: executor count and each executor's interval list.
    logic [6:0]  tbl_count;
    logic [31:0] tbl_start [esrt_pkg::MAX_EXECUTORS][esrt_pkg::LIST_DEPTH];
    logic [31:0] tbl_len   [esrt_pkg::MAX_EXECUTORS][esrt_pkg::LIST_DEPTH];
    int          tbl_used  [esrt_pkg::MAX_EXECUTORS];

    esrt_pkg::esrt_out_t expected_results[$];
    int                  error_count;
    int                  idle_cycles;
    int                  send_idle_pct;

    executor_slot_reservation_table_top u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .item       (item),
        .done       (done),
        .result     (result),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data)
    );

    // Clock with a 2 ns period.
    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    function automatic logic [31:0] end_sum(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[32] ? CMAX : s[31:0];
    endfunction

    function automatic int executors_in_use();
        if (tbl_count < 1)
            return 1;
        if (tbl_count > esrt_pkg::MAX_EXECUTORS)
            return esrt_pkg::MAX_EXECUTORS;
        return int'(tbl_count);
    endfunction

    function automatic logic [31:0] free_cycle(input int e);
        if (tbl_used[e] == 0)
            return '0;
        return end_sum(tbl_start[e][tbl_used[e]-1], tbl_len[e][tbl_used[e]-1]);
    endfunction

    // Compute the result of one item and update the predicted table.
    function automatic esrt_pkg::esrt_out_t table_predict(input esrt_pkg::esrt_in_t it);
        esrt_pkg::esrt_out_t r;
        int          n;
        int          best;
        int          pc;
        int          pos;
        bit          full;
        logic [31:0] best_end;
        logic [31:0] t;
        logic [31:0] ne;
        logic [63:0] inuse;
        r = '0;
        n = executors_in_use();
        inuse = (n >= 64) ? '1 : ((64'd1 << n) - 64'd1);
        if (it.operation == esrt_pkg::OP_FIND)
        begin
            best = 0;
            best_end = free_cycle(0);
            for (int e = 1; e < n; e++)
            begin
                t = free_cycle(e);
                if (it.need_all ? (t > best_end) : (t < best_end))
                begin
                    best_end = t;
                    best = e;
                end
            end
            r.slot_cycle = best_end;
            r.slot_mask = it.need_all ? inuse : (64'd1 << best);
        end
        else if (it.operation == esrt_pkg::OP_SCHED)
        begin
            pc = $countones(it.executor_mask);
            if ((it.executor_mask & ~inuse) != 0 || (pc != 1 && pc != n))
                r.status = esrt_pkg::STATUS_BAD_MASK;
            else
            begin
                full = 0;
                for (int e = 0; e < n; e++)
                    if (it.executor_mask[e] && tbl_used[e] >= esrt_pkg::LIST_DEPTH)
                        full = 1;
                if (full)
                    r.status = esrt_pkg::STATUS_FULL;
                else
                begin
                    ne = end_sum(it.cycle_begin, it.cycle_cost);
                    for (int e = 0; e < n; e++)
                    begin
                        if (!it.executor_mask[e])
                            continue;
                        pos = tbl_used[e];
                        for (int i = 0; i < tbl_used[e]; i++)
                            if (end_sum(tbl_start[e][i], tbl_len[e][i]) > ne)
                            begin
                                pos = i;
                                break;
                            end
                        for (int i = tbl_used[e]; i > pos; i--)
                        begin
                            tbl_start[e][i] = tbl_start[e][i-1];
                            tbl_len[e][i] = tbl_len[e][i-1];
                        end
                        tbl_start[e][pos] = it.cycle_begin;
                        tbl_len[e][pos] = it.cycle_cost;
                        tbl_used[e]++;
                    end
                end
            end
        end
        else if (it.operation == esrt_pkg::OP_STALL)
        begin
            for (int e = 0; e < n; e++)
                for (int i = 0; i < tbl_used[e]; i++)
                    if (tbl_start[e][i] >= it.cycle_begin)
                        tbl_start[e][i] = end_sum(tbl_start[e][i], it.cycle_cost);
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("MISMATCH %s: got %h, want %h at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    // Check each result item against the oldest expectation.
    always @(posedge clk)
    begin
        esrt_pkg::esrt_out_t want;
        if (rst_n && done)
        begin
            if (expected_results.size() == 0)
                report_mismatch("unexpected result", result.slot_mask, 64'd0);
            else
            begin
                want = expected_results.pop_front();
                if (result.slot_cycle !== want.slot_cycle)
                    report_mismatch("slot_cycle", 64'(result.slot_cycle),
                                    64'(want.slot_cycle));
                if (result.slot_mask !== want.slot_mask)
                    report_mismatch("slot_mask", result.slot_mask, want.slot_mask);
                if (result.status !== want.status)
                    report_mismatch("status", 64'(result.status), 64'(want.status));
            end
        end
    end

    // Watchdog on cycles with no accepted item or result.
    always @(posedge clk)
    begin
        if ((start && !busy) || done)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("executor_slot_reservation_table_top test failed");
            $finish;
        end
    end

    // Send one item, with a random gap before it, and record its expectation.
    task automatic send_item(input esrt_pkg::esrt_in_t it);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)
            @(posedge clk);
        start <= 1'b1;
        item <= it;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        expected_results.push_back(table_predict(it));
        start <= 1'b0;
        // The block is busy in this cycle, so leaving it costs no throughput.
        @(posedge clk);
    endtask

    task automatic wait_drained();
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (16) @(posedge clk);
    endtask

    task automatic write_count(input logic [6:0] v);
        wait_drained();
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        tbl_count = v;
        cfg_wr_en <= 1'b0;
    endtask

    function automatic esrt_pkg::esrt_in_t make_item(input logic [1:0] op, input logic na,
                                                     input logic [31:0] b,
                                                     input logic [31:0] c,
                                                     input logic [63:0] m);
        esrt_pkg::esrt_in_t it;
        it.operation = op;
        it.need_all = na;
        it.cycle_begin = b;
        it.cycle_cost = c;
        it.executor_mask = m;
        return it;
    endfunction

    // Mostly legal masks: one executor or all in use, sometimes a wild one.
    function automatic logic [63:0] pick_mask();
        int n;
        n = executors_in_use();
        case ($urandom_range(9))
            0: return {$urandom, $urandom};
            1: return 64'd1 << $urandom_range(63);
            2, 3: return (n >= 64) ? '1 : ((64'd1 << n) - 64'd1);
            default: return 64'd1 << $urandom_range(n - 1);
        endcase
    endfunction

    function automatic logic [31:0] pick_cycle();
        case ($urandom_range(7))
            0: return $urandom;
            1: return CMAX - $urandom_range(15);
            default: return $urandom_range(400);
        endcase
    endfunction

    // Extremes of every field, every operation and the special cases.
    task automatic test_directed();
        write_count(7'd0);
        send_item(make_item(esrt_pkg::OP_FIND, 1'b0, 0, 0, 0));
        send_item(make_item(esrt_pkg::OP_UNUSED, 1'b1, CMAX, CMAX, '1));
        write_count(7'd127);
        send_item(make_item(esrt_pkg::OP_SCHED, 1'b0, 10, 5, 64'h1));
        send_item(make_item(esrt_pkg::OP_SCHED, 1'b0, CMAX - 2, CMAX, 64'h80));
        send_item(make_item(esrt_pkg::OP_SCHED, 1'b0, 0, 0, 64'hFF));
        send_item(make_item(esrt_pkg::OP_SCHED, 1'b0, 0, 0, 64'h3));
        send_item(make_item(esrt_pkg::OP_SCHED, 1'b0, 0, 0, 64'h100));
        send_item(make_item(esrt_pkg::OP_SCHED, 1'b0, 0, 0, '1));
        send_item(make_item(esrt_pkg::OP_SCHED, 1'b0, 0, 0, 64'h0));
        send_item(make_item(esrt_pkg::OP_FIND, 1'b0, 0, 0, 0));
        send_item(make_item(esrt_pkg::OP_FIND, 1'b1, 0, 0, 0));
        send_item(make_item(esrt_pkg::OP_STALL, 1'b0, 5, 100, 0));
        send_item(make_item(esrt_pkg::OP_STALL, 1'b1, 0, CMAX, '1));
        send_item(make_item(esrt_pkg::OP_FIND, 1'b1, 0, 0, 0));
        // Fill executor 2 and then overflow it.
        for (int i = 0; i <= esrt_pkg::LIST_DEPTH; i++)
            send_item(make_item(esrt_pkg::OP_SCHED, 1'b0, 33 - i, i, 64'h4));
        send_item(make_item(esrt_pkg::OP_SCHED, 1'b0, 1, 1, 64'hFF));
        send_item(make_item(esrt_pkg::OP_FIND, 1'b0, 0, 0, 0));
    endtask

    // Random items under one idling setting.
    task automatic test_random(input int count, input int idle_pct);
        logic [1:0] op;
        send_idle_pct = idle_pct;
        for (int k = 0; k < count; k++)
        begin
            op = ($urandom_range(19) == 0) ? esrt_pkg::OP_UNUSED : 2'($urandom_range(2));
            send_item(make_item(op, 1'($urandom), pick_cycle(),
                                ($urandom_range(3) == 0) ? $urandom : $urandom_range(50),
                                pick_mask()));
        end
        send_idle_pct = 0;
    endtask

    // Reset, then the directed part and random phases under several counts.
    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        item = '0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = '0;
        error_count = 0;
        idle_cycles = 0;
        send_idle_pct = 0;
        tbl_count = 7'd1;
        for (int e = 0; e < esrt_pkg::MAX_EXECUTORS; e++)
            tbl_used[e] = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        write_count(7'd1);
        test_random(300, 0);
        write_count(7'd8);
        test_random(300, 45);
        write_count(7'd3);
        test_random(300, 30);
        write_count(7'd64);
        test_random(300, 0);
        write_count(7'd5);
        test_random(300, 45);
        write_count(7'd8);
        test_random(300, 30);

        wait_drained();
        if (error_count == 0)
            $display("executor_slot_reservation_table_top test passed");
        else
            $display("executor_slot_reservation_table_top test failed");
        $finish;
    end

endmodule

### sim.f
+incdir+hw/rtl
hw/rtl/esrt_pkg.sv
hw/rtl/esrt_cell.sv
hw/rtl/esrt_row.sv
hw/rtl/executor_slot_reservation_table_top.sv
verif/tb_executor_slot_reservation_table_top.sv
